// ----- src/assert_macros.svh -----
// Assertion macros shared by the bulk-only transport RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BOT_ASSERT_IMP(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
    else $error("bot assertion failed");

// Next-cycle implication, disabled during reset
`define BOT_ASSERT_NXT(lbl, clk, rstn, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
    else $error("bot assertion failed");

`endif

// ----- src/bot_pkg.sv -----
// Types, codes and helper functions for the bulk-only transport sequencer.
// No dependencies; used by bot_core, bot_out_fifo and the top level.
`default_nettype none

package bot_pkg;

  localparam logic [31:0] CbwSignature = 32'h4342_5355;
  localparam logic [9:0]  CbwBytes     = 10'd31;
  localparam logic [6:0]  CswBytes     = 7'd13;
  localparam logic [6:0]  PacketBytes  = 7'd64;
  localparam logic [7:0]  LunHighMask  = 8'hf0;
  localparam logic [7:0]  CbLenMask    = 8'he0;

  typedef enum logic [1:0] {
    CMD_PACKET  = 2'd0,
    CMD_TX_DONE = 2'd1,
    CMD_RESET   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_BUSY  = 2'd1,
    MODE_ERROR = 2'd2,
    MODE_PHASE = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ACT_STALL = 2'd0,
    ACT_ARM   = 2'd1,
    ACT_DATA  = 2'd2,
    ACT_CSW   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    VERDICT_CONTINUE = 2'd0,
    VERDICT_NO_SENSE = 2'd1,
    VERDICT_SENSE    = 2'd2,
    VERDICT_HW_ERROR = 2'd3
  } verdict_e;

  typedef enum logic [1:0] {
    CSW_PASSED = 2'd0,
    CSW_FAILED = 2'd1,
    CSW_PHASE  = 2'd2,
    CSW_RSVD   = 2'd3
  } csw_status_e;

  // One input word, command kept apart (it travels in tuser)
  typedef struct packed {
    logic [1:0]  command;
    logic [9:0]  rx_byte_count;
    logic [31:0] cbw_signature;
    logic [31:0] cbw_tag;
    logic [31:0] cbw_transfer_length;
    logic [7:0]  cbw_flags;
    logic [7:0]  cbw_lun;
    logic [7:0]  cbw_cb_length;
    logic [1:0]  scsi_result;
    logic [6:0]  tx_ready_bytes;
  } bot_item_t;

  // One result word
  typedef struct packed {
    logic [1:0]  action;
    logic [6:0]  send_length;
    logic [31:0] csw_tag;
    logic [31:0] csw_residue;
    logic [1:0]  csw_status;
    logic        last;
  } bot_result_t;

  // Results produced by one event, pushed into the output queue together
  typedef struct packed {
    logic [1:0]  count;
    bot_result_t r0;
    bot_result_t r1;
  } bot_push_t;

  function automatic bot_result_t res_plain(action_e act);
    bot_result_t r;
    r        = '0;
    r.action = act;
    return r;
  endfunction

  function automatic bot_result_t res_data(logic [6:0] len);
    bot_result_t r;
    r             = '0;
    r.action      = ACT_DATA;
    r.send_length = len;
    return r;
  endfunction

  function automatic bot_result_t res_csw(logic [31:0] tag, logic [31:0] residue,
                                          logic [1:0] status);
    bot_result_t r;
    r             = '0;
    r.action      = ACT_CSW;
    r.send_length = CswBytes;
    r.csw_tag     = tag;
    r.csw_residue = residue;
    r.csw_status  = status;
    return r;
  endfunction

  // Ready count clipped to a packet, then to the host's expected length
  function automatic logic [6:0] clip_len(logic [6:0] ready, logic [31:0] limit);
    logic [6:0] cap;
    cap = (ready > PacketBytes) ? PacketBytes : ready;
    return ({25'd0, cap} > limit) ? limit[6:0] : cap;
  endfunction

  function automatic logic [31:0] abs_diff(logic [31:0] a, logic [31:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

// ----- src/bulk_only_transport_sequencer_unit.sv -----
// Top level of the bulk-only transport sequencer: input register, core, result queue.
// Depends on bot_pkg, bot_core, bot_out_fifo and assert_macros.svh.
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   tdata 144b event fields, tuser command
//  m_axis    out  m_axis_tvalid / m_axis_tready   tdata 80b result fields, tlast
//  cfg       in   cfg_we_i                        cfg_wdata_i max_lun
//
// An event is decoded straight from the input register in the cycle after acceptance,
// and its words are written into the result queue once the queue has room for two words.
// Sustained rate is one event per cycle while that room lasts; an event giving two
// words hands them out one after the other, set by the one-word-per-cycle output
// of the result queue.
// Reset clears the mode and saved wrapper state; max_lun resets to zero.
// The input stalls while the four-word result queue lacks room for two words.
`default_nettype none

module bulk_only_transport_sequencer_unit (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          cfg_we_i,
  input  wire  [3:0]   cfg_wdata_i,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  // rx_byte_count[9:0], cbw_signature[41:10], cbw_tag[73:42],
  // cbw_transfer_length[105:74], cbw_flags[113:106], cbw_lun[121:114],
  // cbw_cb_length[129:122], scsi_result[131:130], tx_ready_bytes[138:132], zero pad
  input  wire  [143:0] s_axis_tdata,
  // command[1:0]
  input  wire  [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // action[1:0], send_length[8:2], csw_tag[40:9], csw_residue[72:41],
  // csw_status[74:73], zero pad
  output logic [79:0]  m_axis_tdata,
  output logic         m_axis_tlast
);
  import bot_pkg::*;

  `include "assert_macros.svh"

  logic [3:0]  max_lun_q;
  logic        in_vld_q;
  bot_item_t   item_q, item_d;
  logic        fire, room2, pop;
  logic [2:0]  fifo_cnt;
  bot_push_t   push;
  bot_result_t head;
  mode_e       mode;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_lun_q <= '0;
    else if (cfg_we_i) max_lun_q <= cfg_wdata_i;
  end

  // Input register
  assign fire          = in_vld_q && room2;
  assign s_axis_tready = !in_vld_q || fire;

  always_comb begin
    item_d.command             = s_axis_tuser;
    item_d.rx_byte_count       = s_axis_tdata[9:0];
    item_d.cbw_signature       = s_axis_tdata[41:10];
    item_d.cbw_tag             = s_axis_tdata[73:42];
    item_d.cbw_transfer_length = s_axis_tdata[105:74];
    item_d.cbw_flags           = s_axis_tdata[113:106];
    item_d.cbw_lun             = s_axis_tdata[121:114];
    item_d.cbw_cb_length       = s_axis_tdata[129:122];
    item_d.scsi_result         = s_axis_tdata[131:130];
    item_d.tx_ready_bytes      = s_axis_tdata[138:132];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) in_vld_q <= 1'b0;
    else if (s_axis_tready) in_vld_q <= s_axis_tvalid;
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) item_q <= item_d;
  end

  bot_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .max_lun_i (max_lun_q),
    .push_o    (push),
    .mode_o    (mode)
  );

  assign pop = m_axis_tvalid && m_axis_tready;

  bot_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room2_o (room2),
    .count_o (fifo_cnt)
  );

  // Output packing
  assign m_axis_tdata = {5'd0, head.csw_status, head.csw_residue, head.csw_tag,
                         head.send_length, head.action};
  assign m_axis_tlast = head.last;

  // Checks
  `BOT_ASSERT_IMP(a_fifo_bound, clk_i, rst_ni, 1'b1, fifo_cnt <= 3'd4)
  `BOT_ASSERT_NXT(a_reset_idle, clk_i, rst_ni,
    fire && item_q.command == CMD_RESET, mode == MODE_IDLE)
  `BOT_ASSERT_IMP(a_error_quiet, clk_i, rst_ni,
    fire && mode == MODE_ERROR && item_q.command != CMD_RESET, push.count == 2'd0)
  `BOT_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, !s_axis_tready, in_vld_q && !room2)

endmodule

`default_nettype wire

// ----- src/bot_core.sv -----
// Sequencer state and per-event decode: CBW checks, data, status and stalls.
// Depends on bot_pkg.
`default_nettype none

module bot_core (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fire_i,
  input  bot_pkg::bot_item_t  item_i,
  input  wire  [3:0]          max_lun_i,
  output bot_pkg::bot_push_t  push_o,
  output bot_pkg::mode_e      mode_o
);
  import bot_pkg::*;

  mode_e       mode_q, mode_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] exp_q, exp_d;
  logic        to_host_q, to_host_d;
  logic [31:0] moved_q, moved_d;

  logic        cbw_bad;
  logic [6:0]  len_new, len_busy;
  logic [31:0] moved_rx;
  logic [1:0]  csw_st;
  mode_e       csw_mode;
  bot_push_t   push;

  // CBW validity and shared arithmetic
  assign cbw_bad = (item_i.rx_byte_count != CbwBytes) ||
                   (item_i.cbw_signature != CbwSignature) ||
                   ((item_i.cbw_lun & LunHighMask) != 8'd0) ||
                   ((item_i.cbw_cb_length & CbLenMask) != 8'd0) ||
                   (item_i.cbw_lun > {4'd0, max_lun_i});
  assign len_new  = clip_len(item_i.tx_ready_bytes, item_i.cbw_transfer_length);
  assign len_busy = clip_len(item_i.tx_ready_bytes, exp_q);
  assign moved_rx = moved_q + {22'd0, item_i.rx_byte_count};

  // Status code and following mode for a final verdict
  always_comb begin
    if (item_i.scsi_result == VERDICT_HW_ERROR) begin
      csw_st   = CSW_PHASE;
      csw_mode = MODE_PHASE;
    end else begin
      csw_st   = (item_i.scsi_result == VERDICT_NO_SENSE) ? CSW_PASSED : CSW_FAILED;
      csw_mode = MODE_IDLE;
    end
  end

  // Next state and results
  always_comb begin
    mode_d     = mode_q;
    tag_d      = tag_q;
    exp_d      = exp_q;
    to_host_d  = to_host_q;
    moved_d    = moved_q;
    push       = '0;
    case (item_i.command)
      CMD_RESET: begin
        mode_d     = MODE_IDLE;
        push.count = 2'd1;
        push.r0    = res_plain(ACT_ARM);
      end
      CMD_PACKET, CMD_TX_DONE: begin
        case (mode_q)
          MODE_ERROR: ;
          MODE_PHASE: begin
            push.count = 2'd1;
            push.r0    = res_plain(ACT_STALL);
          end
          MODE_IDLE: begin
            push.count = 2'd1;
            if (item_i.command == CMD_TX_DONE) begin
              push.r0 = res_plain(ACT_ARM);
            end else if (cbw_bad) begin
              mode_d  = MODE_ERROR;
              push.r0 = res_plain(ACT_STALL);
            end else begin
              mode_d    = MODE_BUSY;
              tag_d     = item_i.cbw_tag;
              exp_d     = item_i.cbw_transfer_length;
              to_host_d = item_i.cbw_flags[7];
              moved_d   = '0;
              if (item_i.scsi_result == VERDICT_CONTINUE) begin
                if (item_i.cbw_flags[7]) begin
                  moved_d = {25'd0, len_new};
                  push.r0 = res_data(len_new);
                end else begin
                  push.r0 = res_plain(ACT_ARM);
                end
              end else begin
                // moved count is zero here, so the residue is the expected length
                mode_d  = csw_mode;
                push.r0 = res_csw(item_i.cbw_tag, item_i.cbw_transfer_length, csw_st);
              end
            end
          end
          default: begin
            // busy
            if (item_i.command == CMD_PACKET) begin
              if (to_host_q) begin
                mode_d     = MODE_ERROR;
                push.count = 2'd1;
                push.r0    = res_plain(ACT_STALL);
              end else begin
                moved_d = moved_rx;
                if (item_i.scsi_result != VERDICT_CONTINUE) begin
                  mode_d     = csw_mode;
                  push.count = 2'd2;
                  push.r0    = res_csw(tag_q, abs_diff(exp_q, moved_rx), csw_st);
                  push.r1    = res_plain(ACT_ARM);
                end else begin
                  push.count = 2'd1;
                  push.r0    = res_plain(ACT_ARM);
                end
              end
            end else begin
              push.count = 2'd1;
              if (item_i.scsi_result == VERDICT_CONTINUE) begin
                moved_d = moved_q + {25'd0, len_busy};
                push.r0 = res_data(len_busy);
              end else begin
                mode_d  = csw_mode;
                push.r0 = res_csw(tag_q, abs_diff(exp_q, moved_q), csw_st);
              end
            end
          end
        endcase
      end
      default: ;
    endcase
    // Mark the final result of this event
    if (push.count == 2'd1) push.r0.last = 1'b1;
    if (push.count == 2'd2) push.r1.last = 1'b1;
  end

  assign push_o = fire_i ? push : '0;
  assign mode_o = mode_q;

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      tag_q     <= '0;
      exp_q     <= '0;
      to_host_q <= 1'b0;
      moved_q   <= '0;
    end else if (fire_i) begin
      mode_q    <= mode_d;
      tag_q     <= tag_d;
      exp_q     <= exp_d;
      to_host_q <= to_host_d;
      moved_q   <= moved_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/bot_out_fifo.sv -----
// Four-entry result queue: takes up to two words a cycle, hands out one.
// Depends on bot_pkg.
`default_nettype none

module bot_out_fifo (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  bot_pkg::bot_push_t   push_i,
  input  wire                  pop_i,
  output bot_pkg::bot_result_t head_o,
  output logic                 valid_o,
  output logic                 room2_o,
  output logic [2:0]           count_o
);
  import bot_pkg::*;

  bot_result_t mem_q [4];
  logic [1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [1:0]  wr_p1;

  assign wr_p1 = wr_q + 2'd1;

  // Pointer and fill count update
  always_comb begin
    wr_d  = wr_q + push_i.count;
    rd_d  = rd_q + {1'b0, pop_i};
    cnt_d = cnt_q + {1'b0, push_i.count} - {2'd0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q]  <= push_i.r0;
    if (push_i.count == 2'd2) mem_q[wr_p1] <= push_i.r1;
  end

  assign head_o  = mem_q[rd_q];
  assign valid_o = (cnt_q != 3'd0);
  assign room2_o = (cnt_q <= 3'd2);
  assign count_o = cnt_q;

endmodule

`default_nettype wire

// ----- tb/sv/tb_bulk_only_transport_sequencer_unit.sv -----
// Self-checking testbench for the bulk-only transport sequencer: predicts every result word
// from its own copy of the sequencer state. Depends on bot_pkg and the top-level RTL only.
module tb_bulk_only_transport_sequencer_unit;
  import bot_pkg::*;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 12;
  localparam int PhaseItems   = 300;
  localparam int ReportLimit  = 10;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic [3:0]   cfg_wdata_i   = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = CMD_PACKET;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [79:0]  m_axis_tdata;
  logic         m_axis_tlast;

  bulk_only_transport_sequencer_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Sequencer state as the testbench sees it
  // ---------------------------------------------------------------------------
  mode_e       bot_mode   = MODE_IDLE;
  logic [31:0] held_tag   = '0;
  logic [31:0] host_len   = '0;
  logic        dir_in     = 1'b0;
  logic [31:0] xfer_count = '0;
  logic [3:0]  lun_limit  = '0;

  bot_result_t expected_words[$];
  bot_item_t   pending_events[$];
  int          issued_count   = 0;
  int          accepted_count = 0;
  int          useful_count   = 0;
  int          fail_count     = 0;
  int          cycle_count    = 0;
  int          ev_kind_count[4];
  int          word_kind_count[4];

  function automatic bot_result_t plain_word(action_e act);
    bot_result_t w;
    w        = '0;
    w.action = act;
    return w;
  endfunction

  // Data word: ready count capped at a packet, then at the host's expected length
  function automatic bot_result_t data_word(logic [6:0] ready);
    logic [6:0]  n;
    bot_result_t w;
    n = (ready > PacketBytes) ? PacketBytes : ready;
    if ({25'd0, n} > host_len) n = host_len[6:0];
    xfer_count   += {25'd0, n};
    w             = plain_word(ACT_DATA);
    w.send_length = n;
    return w;
  endfunction

  // Status wrapper closes the command; a hardware error leaves a phase error behind
  function automatic bot_result_t status_word(verdict_e v);
    bot_result_t w;
    w             = plain_word(ACT_CSW);
    w.send_length = CswBytes;
    w.csw_tag     = held_tag;
    w.csw_residue = (host_len > xfer_count) ? host_len - xfer_count : xfer_count - host_len;
    if (v == VERDICT_HW_ERROR) begin
      bot_mode     = MODE_PHASE;
      w.csw_status = CSW_PHASE;
    end else begin
      bot_mode     = MODE_IDLE;
      w.csw_status = (v == VERDICT_NO_SENSE) ? CSW_PASSED : CSW_FAILED;
    end
    return w;
  endfunction

  // Advance the state by one event and queue the words it should produce
  function automatic void predict_event(bot_item_t ev);
    bot_result_t words[$];
    verdict_e    v;
    logic        cbw_ok;
    v = verdict_e'(ev.scsi_result);
    case (ev.command)
      CMD_RESET: begin
        bot_mode = MODE_IDLE;
        words.push_back(plain_word(ACT_ARM));
      end
      CMD_UNUSED: ;
      default: begin
        case (bot_mode)
          MODE_ERROR: ;
          MODE_PHASE: words.push_back(plain_word(ACT_STALL));
          MODE_IDLE: begin
            if (ev.command == CMD_PACKET) begin
              cbw_ok = ev.rx_byte_count == CbwBytes && ev.cbw_signature == CbwSignature &&
                       (ev.cbw_lun & LunHighMask) == '0 &&
                       (ev.cbw_cb_length & CbLenMask) == '0 &&
                       ev.cbw_lun <= {4'd0, lun_limit};
              if (!cbw_ok) begin
                bot_mode = MODE_ERROR;
                words.push_back(plain_word(ACT_STALL));
              end else begin
                bot_mode   = MODE_BUSY;
                held_tag   = ev.cbw_tag;
                host_len   = ev.cbw_transfer_length;
                dir_in     = ev.cbw_flags[7];
                xfer_count = '0;
                if (v != VERDICT_CONTINUE) words.push_back(status_word(v));
                else if (dir_in) words.push_back(data_word(ev.tx_ready_bytes));
                else words.push_back(plain_word(ACT_ARM));
              end
            end else begin
              words.push_back(plain_word(ACT_ARM));
            end
          end
          default: begin
            if (ev.command == CMD_PACKET) begin
              if (dir_in) begin
                // host wrote while we were sending: protocol error
                bot_mode = MODE_ERROR;
                words.push_back(plain_word(ACT_STALL));
              end else begin
                xfer_count += {22'd0, ev.rx_byte_count};
                if (v != VERDICT_CONTINUE) words.push_back(status_word(v));
                words.push_back(plain_word(ACT_ARM));
              end
            end else if (v == VERDICT_CONTINUE) begin
              words.push_back(data_word(ev.tx_ready_bytes));
            end else begin
              words.push_back(status_word(v));
            end
          end
        endcase
      end
    endcase
    if (words.size() != 0) words[words.size() - 1].last = 1'b1;
    foreach (words[i]) expected_words.push_back(words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Event builders
  // ---------------------------------------------------------------------------
  function automatic logic [6:0] pick_ready();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(0, 64));
  endfunction

  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      4, 5:    return $urandom_range(1, 64);
      default: return $urandom_range(0, 400);
    endcase
  endfunction

  function automatic bot_item_t noise_event();
    bot_item_t ev;
    ev.command             = 2'($urandom_range(CMD_PACKET, CMD_UNUSED));
    ev.rx_byte_count       = 10'($urandom);
    ev.cbw_signature       = $urandom;
    ev.cbw_tag             = $urandom;
    ev.cbw_transfer_length = $urandom;
    ev.cbw_flags           = 8'($urandom);
    ev.cbw_lun             = 8'($urandom);
    ev.cbw_cb_length       = 8'($urandom);
    ev.scsi_result         = 2'($urandom);
    ev.tx_ready_bytes      = pick_ready();
    return ev;
  endfunction

  function automatic bot_item_t reset_event();
    bot_item_t ev;
    ev         = noise_event();
    ev.command = CMD_RESET;
    return ev;
  endfunction

  // Packet or transmit-done with random content; ignored in error mode
  function automatic bot_item_t filler_event();
    bot_item_t ev;
    ev         = noise_event();
    ev.command = $urandom_range(0, 1) ? CMD_TX_DONE : CMD_PACKET;
    return ev;
  endfunction

  function automatic bot_item_t cbw_event(logic to_host, logic [31:0] xlen, logic [3:0] cap);
    bot_item_t ev;
    ev                     = noise_event();
    ev.command             = CMD_PACKET;
    ev.rx_byte_count       = CbwBytes;
    ev.cbw_signature       = CbwSignature;
    ev.cbw_transfer_length = xlen;
    ev.cbw_flags[7]        = to_host;
    ev.cbw_lun             = 8'($urandom_range(0, cap));
    ev.cbw_cb_length       = {3'b000, 5'($urandom)};
    ev.scsi_result         = VERDICT_CONTINUE;
    return ev;
  endfunction

  // Follow-up of a command: data sent to the host, or a packet from it
  function automatic bot_item_t step_event(logic to_host, verdict_e v);
    bot_item_t ev;
    ev             = noise_event();
    ev.scsi_result = v;
    if (to_host) begin
      ev.command = CMD_TX_DONE;
    end else begin
      ev.command       = CMD_PACKET;
      ev.rx_byte_count = ($urandom_range(0, 5) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, 64));
    end
    return ev;
  endfunction

  function automatic verdict_e final_verdict();
    int r;
    r = $urandom_range(0, 19);
    if (r < 9) return VERDICT_NO_SENSE;
    if (r < 18) return VERDICT_SENSE;
    return VERDICT_HW_ERROR;
  endfunction

  // Command wrapper with one check broken
  function automatic bot_item_t bad_cbw(logic [3:0] cap);
    bot_item_t ev;
    ev = cbw_event(1'($urandom), pick_length(), cap);
    case ($urandom_range(0, 4))
      0: ev.rx_byte_count = CbwBytes ^ 10'($urandom_range(1, 1023));
      1: ev.cbw_signature = CbwSignature ^ (32'h1 << $urandom_range(0, 31));
      2: ev.cbw_lun[7:4] = 4'($urandom_range(1, 15));
      3: ev.cbw_cb_length[7:5] = 3'($urandom_range(1, 7));
      default: begin
        if (cap == 4'hf) ev.cbw_lun[7:4] = 4'($urandom_range(1, 15));
        else ev.cbw_lun = 8'($urandom_range(cap + 1, 15));
      end
    endcase
    return ev;
  endfunction

  task automatic add_event(bot_item_t ev, bit counts);
    pending_events.push_back(ev);
    issued_count++;
    if (counts) useful_count++;
  endtask

  // One command from wrapper to status, or a broken / noisy stretch
  task automatic gen_transaction(logic [3:0] cap);
    int        kind;
    logic      to_host;
    bot_item_t ev;
    kind = $urandom_range(0, 99);
    if ($urandom_range(0, 6) == 0) add_event(reset_event(), 1);
    if (kind < 8) begin
      add_event(noise_event(), 1);
      add_event(reset_event(), 1);
    end else if (kind < 18) begin
      add_event(bad_cbw(cap), 1);
      repeat ($urandom_range(0, 3)) add_event(filler_event(), 0);
      add_event(reset_event(), 1);
    end else begin
      to_host = 1'($urandom);
      ev      = cbw_event(to_host, pick_length(), cap);
      if ($urandom_range(0, 4) == 0)
        ev.scsi_result = 2'($urandom_range(VERDICT_NO_SENSE, VERDICT_HW_ERROR));
      add_event(ev, 1);
      if (ev.scsi_result == VERDICT_CONTINUE) begin
        repeat ($urandom_range(0, 6)) add_event(step_event(to_host, VERDICT_CONTINUE), 1);
        if (kind < 26 && to_host) begin
          add_event(step_event(1'b0, VERDICT_CONTINUE), 1);
          repeat ($urandom_range(0, 2)) add_event(filler_event(), 0);
          add_event(reset_event(), 1);
          return;
        end
        ev = step_event(to_host, final_verdict());
        add_event(ev, 1);
      end
      if (ev.scsi_result == VERDICT_HW_ERROR) begin
        repeat ($urandom_range(1, 3)) add_event(filler_event(), 1);
        add_event(reset_event(), 1);
      end
    end
  endtask

  task automatic wait_drained();
    while (accepted_count != issued_count || expected_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_max_lun(logic [3:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    lun_limit    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of words with random gaps
  // ---------------------------------------------------------------------------
  bot_item_t live_event;
  int        burst_left = 1;
  int        gap_left   = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_event(live_event);
        accepted_count++;
        ev_kind_count[live_event.command]++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_events.size() != 0 && gap_left == 0) begin
          live_event     = pending_events.pop_front();
          s_axis_tdata  <= {5'd0, live_event.tx_ready_bytes, live_event.scsi_result,
                            live_event.cbw_cb_length, live_event.cbw_lun,
                            live_event.cbw_flags, live_event.cbw_transfer_length,
                            live_event.cbw_tag, live_event.cbw_signature,
                            live_event.rx_byte_count};
          s_axis_tuser  <= live_event.command;
          s_axis_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
          if (gap_left != 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: receiver stalls, word checks, run timeout
  // ---------------------------------------------------------------------------
  int          stall_style = 0;
  bot_result_t got_word;
  bot_result_t want_word;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count[7:0] == 8'd0) stall_style = $urandom_range(0, 3);
    case (stall_style)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= cycle_count[2];
      default: m_axis_tready <= ($urandom_range(0, 4) == 0);
    endcase

    if (m_axis_tvalid && m_axis_tready) begin
      got_word.action      = m_axis_tdata[1:0];
      got_word.send_length = m_axis_tdata[8:2];
      got_word.csw_tag     = m_axis_tdata[40:9];
      got_word.csw_residue = m_axis_tdata[72:41];
      got_word.csw_status  = m_axis_tdata[74:73];
      got_word.last        = m_axis_tlast;
      word_kind_count[got_word.action]++;
      if (expected_words.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("[%0d] unexpected word: act=%0d len=%0d tag=%h res=%h st=%0d last=%b",
                   cycle_count, got_word.action, got_word.send_length, got_word.csw_tag,
                   got_word.csw_residue, got_word.csw_status, got_word.last);
      end else begin
        want_word = expected_words.pop_front();
        if (got_word !== want_word) begin
          fail_count++;
          if (fail_count <= ReportLimit) begin
            $display("[%0d] word mismatch", cycle_count);
            $display("  expected act=%0d len=%0d tag=%h res=%h st=%0d last=%b",
                     want_word.action, want_word.send_length, want_word.csw_tag,
                     want_word.csw_residue, want_word.csw_status, want_word.last);
            $display("  actual   act=%0d len=%0d tag=%h res=%h st=%0d last=%b",
                     got_word.action, got_word.send_length, got_word.csw_tag,
                     got_word.csw_residue, got_word.csw_status, got_word.last);
          end
        end
      end
    end

    if (cycle_count == CycleLimit) begin
      $display("timeout: %0d of %0d events accepted, %0d words outstanding",
               accepted_count, issued_count, expected_words.size());
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    bot_item_t   ev;
    logic [3:0]  cap;
    int          target;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, max_lun at its reset value of zero
    ev = filler_event(); ev.command = CMD_TX_DONE; add_event(ev, 1);   // idle: arm
    ev = noise_event(); ev.command = CMD_UNUSED; add_event(ev, 1);     // no result
    ev = cbw_event(1'b0, 32'd0, 4'd0);
    ev.cbw_cb_length = 8'h1f; ev.scsi_result = VERDICT_NO_SENSE; add_event(ev, 1);
    // data to host, ready counts above a packet, clipped to expected length
    ev = cbw_event(1'b1, 32'd32, 4'd0); ev.tx_ready_bytes = 7'd127; add_event(ev, 1);
    ev = step_event(1'b1, VERDICT_CONTINUE); ev.tx_ready_bytes = 7'd65; add_event(ev, 1);
    add_event(step_event(1'b1, VERDICT_SENSE), 1);
    // data from host, largest lengths, hardware error gives phase error
    add_event(cbw_event(1'b0, 32'hffff_ffff, 4'd0), 1);
    ev = step_event(1'b0, VERDICT_CONTINUE); ev.rx_byte_count = 10'h3ff; add_event(ev, 1);
    ev = step_event(1'b0, VERDICT_HW_ERROR); ev.rx_byte_count = 10'd0; add_event(ev, 1);
    ev = filler_event(); ev.command = CMD_TX_DONE; add_event(ev, 1);
    ev = filler_event(); ev.command = CMD_PACKET; add_event(ev, 1);
    add_event(reset_event(), 1);
    // logical unit above the limit
    ev = cbw_event(1'b0, 32'd8, 4'd0); ev.cbw_lun = 8'd1; add_event(ev, 1);
    ev = filler_event(); ev.command = CMD_TX_DONE; add_event(ev, 1);
    add_event(reset_event(), 1);
    wait_drained();

    set_max_lun(4'd15);
    ev = cbw_event(1'b1, 32'hffff_ffff, 4'd0); ev.cbw_lun = 8'd15;
    ev.tx_ready_bytes = 7'd64; add_event(ev, 1);
    add_event(step_event(1'b0, VERDICT_CONTINUE), 1);                   // protocol error
    add_event(reset_event(), 1);
    ev = cbw_event(1'b0, 32'd0, 4'd15); ev.cbw_signature = '1; add_event(ev, 1);
    add_event(reset_event(), 1);
    ev = cbw_event(1'b0, 32'd0, 4'd15); ev.cbw_lun = 8'h10; add_event(ev, 1);
    add_event(reset_event(), 1);
    ev = cbw_event(1'b0, 32'd0, 4'd15); ev.cbw_cb_length = 8'hff; add_event(ev, 1);
    add_event(reset_event(), 1);
    ev = cbw_event(1'b0, 32'd0, 4'd15); ev.rx_byte_count = 10'd30; add_event(ev, 1);
    add_event(reset_event(), 1);
    // more received than expected: residue is the overshoot, then re-arm
    add_event(cbw_event(1'b0, 32'd10, 4'd15), 1);
    ev = step_event(1'b0, VERDICT_NO_SENSE); ev.rx_byte_count = 10'd20; add_event(ev, 1);
    wait_drained();

    // Random phases across several logical-unit limits
    for (int p = 0; p < 5; p++) begin
      case (p)
        0, 4:    cap = 4'd15;
        1:       cap = 4'd0;
        default: cap = 4'($urandom_range(1, 14));
      endcase
      set_max_lun(cap);
      target = useful_count + PhaseItems;
      while (useful_count < target) gen_transaction(cap);
      wait_drained();
    end

    $display("covered %0d events: %0d packets, %0d transmit-done, %0d resets, %0d unused codes",
             accepted_count, ev_kind_count[CMD_PACKET], ev_kind_count[CMD_TX_DONE],
             ev_kind_count[CMD_RESET], ev_kind_count[CMD_UNUSED]);
    $display("result words: %0d stall, %0d arm, %0d data, %0d status; %0d failures",
             word_kind_count[ACT_STALL], word_kind_count[ACT_ARM],
             word_kind_count[ACT_DATA], word_kind_count[ACT_CSW], fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/bot_pkg.sv
src/bot_core.sv
src/bot_out_fifo.sv
src/bulk_only_transport_sequencer_unit.sv
tb/sv/tb_bulk_only_transport_sequencer_unit.sv
